FILE: rtl/cts_pkg.sv
package cts_pkg;

  localparam int TIME_W     = 32;
  localparam int POS_W      = 32;
  localparam int VEL_W      = 48;
  localparam int ACC_W      = 64;
  localparam int TICK_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_POS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TICKS = 2'd3;

  typedef logic        [TIME_W-1:0] time_val_t;
  typedef logic signed [POS_W-1:0]  pos_val_t;
  typedef logic signed [VEL_W-1:0]  vel_val_t;
  typedef logic signed [ACC_W-1:0]  acc_val_t;

endpackage

FILE: rtl/cts_if.sv
interface cts_in_if;
  import cts_pkg::*;

  logic      valid;
  logic      ready;
  time_val_t sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink (input valid, input sample_time, output ready);
endinterface

interface cts_out_if;
  import cts_pkg::*;

  logic     valid;
  logic     ready;
  pos_val_t position;
  vel_val_t velocity;
  acc_val_t acceleration;
  logic     time_clamped;

  modport source (output valid, output position, output velocity, output acceleration,
                  output time_clamped, input ready);
  modport sink (input valid, input position, input velocity, input acceleration,
                input time_clamped, output ready);
endinterface

FILE: rtl/cubic_trajectory_sampler.sv
// Channel   | Dir | Handshake       | Payload
// ----------+-----+-----------------+-----------------------------------------------
// in_chan   | in  | valid / ready   | sample_time
// out_chan  | out | valid / ready   | position, velocity, acceleration, time_clamped
// cfg_*     | in  | cfg_we (no ack) | cfg_index, cfg_wdata
//
// One request per cycle is taken while the skid register is empty; the pipeline depth is
// set by the bit-per-stage dividers: 24 + FRACTION_BITS stages for the normalized time,
// then 68 stages in each of the velocity and acceleration dividers, run in lockstep.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output parks one result in a skid register; the whole pipe holds while
// the skid is full, so nothing is dropped or repeated.
module cubic_trajectory_sampler #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  cts_in_if.sink                          in_chan,
  cts_out_if.source                       out_chan
);
  import cts_pkg::*;

  localparam int F     = FRACTION_BITS;
  localparam int S_W   = F + 1;            // normalized time, up to 2^F
  localparam int SN_W  = TICK_W + F;       // numerator of the time divider
  localparam int G_W   = F + 3;            // 6*(s - s2)
  localparam int K_W   = F + 4;            // 12*s
  localparam int KM_W  = F + 3;            // |6 - 12 s|
  localparam int DM_W  = 33;               // |goal - start|
  localparam int PM_W  = DM_W + S_W;
  localparam int VN_W  = DM_W + G_W;
  localparam int AN_W  = DM_W + KM_W;
  localparam int VX_W  = VN_W + 16;
  localparam int Q_W   = AN_W + 32 - F;    // shared divider width
  localparam int SQ_W  = 2 * S_W;

  typedef struct packed {
    pos_val_t pos;
    vel_val_t vel;
    acc_val_t acc;
    logic     clamped;
  } res_t;

  // ---------------- configuration registers ----------------
  logic [31:0]       sp_r, gp_r, st_r;
  logic [TICK_W-1:0] mt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      gp_r <= '0;
      st_r <= '0;
      mt_r <= TICK_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_POS:  sp_r <= cfg_wdata;
        CFG_GOAL_POS:   gp_r <= cfg_wdata;
        CFG_START_TIME: st_r <= cfg_wdata;
        CFG_MOVE_TICKS: mt_r <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived move constants, registered from the configuration registers.
  logic [TICK_W-1:0]   tk;
  logic [DM_W-1:0]     dsgn;
  logic [TICK_W-1:0]   ticks_r;
  logic [32:0]         win_end_r;
  logic [2*TICK_W-1:0] tsq_r;
  logic [DM_W-1:0]     dmag_r;
  logic                dneg_r;

  assign tk   = (mt_r == '0) ? TICK_W'(1) : mt_r;
  assign dsgn = {gp_r[31], gp_r} - {sp_r[31], sp_r};

  always_ff @(posedge clk) begin
    ticks_r   <= tk;
    win_end_r <= {1'b0, st_r} + 33'(tk);
    tsq_r     <= (2*TICK_W)'(tk) * (2*TICK_W)'(tk);
    dneg_r    <= dsgn[DM_W-1];
    dmag_r    <= dsgn[DM_W-1] ? (~dsgn + DM_W'(1)) : dsgn;
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic sk_v_r, out_v_r;

  assign en            = ~sk_v_r;
  assign in_chan.ready = en;

  // ---------------- stage T0: capture request ----------------
  logic        t0_v_r;
  logic [31:0] t0_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t0_v_r <= 1'b0;
    else if (en) t0_v_r <= in_chan.valid & in_chan.ready;
  end

  always_ff @(posedge clk) begin
    if (en) t0_t_r <= in_chan.sample_time;
  end

  // Clamp to the window; the window end is 33 bits wide.
  logic              gt_w, lt_w, cl_w;
  logic [TICK_W-1:0] el_w;

  assign gt_w = {1'b0, t0_t_r} > win_end_r;
  assign lt_w = t0_t_r < st_r;
  assign cl_w = gt_w | lt_w;
  assign el_w = gt_w ? ticks_r : (lt_w ? '0 : TICK_W'(t0_t_r - st_r));

  // ---------------- normalized time s = floor(e * 2^F / ticks) ----------------
  logic            sd_v, sd_cl;
  logic [SN_W-1:0] sd_q;

  cts_div #(.NUM_W(SN_W), .DEN_W(TICK_W), .SIDE_W(1)) u_sdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t0_v_r),
    .in_num    ({el_w, {F{1'b0}}}),
    .in_den    (ticks_r),
    .in_side   (cl_w),
    .out_valid (sd_v),
    .out_quo   (sd_q),
    .out_side  (sd_cl)
  );

  // ---------------- M1: s*s ----------------
  logic            m1_v_r, m1_cl_r;
  logic [S_W-1:0]  m1_s_r;
  logic [SQ_W-1:0] m1_sq_r;

  // ---------------- M2: s2*s ----------------
  logic            m2_v_r, m2_cl_r;
  logic [S_W-1:0]  m2_s_r, m2_s2_r;
  logic [SQ_W-1:0] m2_cu_r;

  // ---------------- M3: h, g, k ----------------
  logic            m3_v_r, m3_cl_r, m3_kneg_r;
  logic [S_W-1:0]  m3_h_r;
  logic [G_W-1:0]  m3_g_r;
  logic [KM_W-1:0] m3_km_r;

  // ---------------- M4: products with |d| ----------------
  logic            m4_v_r, m4_cl_r, m4_kneg_r;
  logic [PM_W-1:0] m4_pm_r;
  logic [VN_W-1:0] m4_vn_r;
  logic [AN_W-1:0] m4_an_r;

  // ---------------- M5: position, divider numerators ----------------
  logic            m5_v_r, m5_cl_r, m5_vneg_r, m5_aneg_r;
  pos_val_t        m5_pos_r;
  logic [Q_W-1:0]  m5_vn_r, m5_an_r;

  logic [S_W-1:0]  s_w, s2_w, s3_w, h_w, df_w;
  logic [G_W-1:0]  h3_w, g_w;
  logic [K_W-1:0]  s12_w, six_w;
  logic            kneg_w;
  logic [KM_W-1:0] km_w;
  logic [31:0]     pmag_w;
  logic [VX_W-1:0] vx_w;

  assign s_w    = sd_q[S_W-1:0];
  assign s2_w   = m1_sq_r[F +: S_W];
  assign s3_w   = m2_cu_r[F +: S_W];
  // 3*s2 - 2*s3 never goes negative since s3 <= s2; saturate at one.
  assign h3_w   = {2'b0, m2_s2_r} + {1'b0, m2_s2_r, 1'b0} - {1'b0, s3_w, 1'b0};
  assign h_w    = (h3_w > (G_W'(1) << F)) ? (S_W'(1) << F) : h3_w[S_W-1:0];
  assign df_w   = m2_s_r - m2_s2_r;
  assign g_w    = {df_w, 2'b0} + {1'b0, df_w, 1'b0};
  assign s12_w  = {m2_s_r, 3'b0} + {1'b0, m2_s_r, 2'b0};
  assign six_w  = K_W'(6) << F;
  assign kneg_w = s12_w > six_w;
  assign km_w   = KM_W'(kneg_w ? (s12_w - six_w) : (six_w - s12_w));
  assign pmag_w = m4_pm_r[F +: 32];
  // floor(vn * 2^16 / 2^F), exact for any F
  assign vx_w   = {m4_vn_r, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
      m5_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= sd_v;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
      m5_v_r <= m4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_s_r    <= s_w;
      m1_cl_r   <= sd_cl;
      m1_sq_r   <= SQ_W'(s_w) * SQ_W'(s_w);

      m2_s_r    <= m1_s_r;
      m2_s2_r   <= s2_w;
      m2_cl_r   <= m1_cl_r;
      m2_cu_r   <= SQ_W'(s2_w) * SQ_W'(m1_s_r);

      m3_h_r    <= h_w;
      m3_g_r    <= g_w;
      m3_km_r   <= km_w;
      m3_kneg_r <= kneg_w;
      m3_cl_r   <= m2_cl_r;

      m4_pm_r   <= PM_W'(dmag_r) * PM_W'(m3_h_r);
      m4_vn_r   <= VN_W'(dmag_r) * VN_W'(m3_g_r);
      m4_an_r   <= AN_W'(dmag_r) * AN_W'(m3_km_r);
      m4_kneg_r <= m3_kneg_r;
      m4_cl_r   <= m3_cl_r;

      m5_pos_r  <= dneg_r ? (sp_r - pmag_w) : (sp_r + pmag_w);
      m5_vn_r   <= Q_W'(vx_w[VX_W-1:F]);
      m5_an_r   <= {m4_an_r, {(32-F){1'b0}}};
      m5_vneg_r <= dneg_r;
      m5_aneg_r <= dneg_r ^ m4_kneg_r;
      m5_cl_r   <= m4_cl_r;
    end
  end

  // ---------------- velocity and acceleration dividers, in lockstep ----------------
  logic           vd_v, vd_neg, ad_v;
  logic [Q_W-1:0] vd_q, ad_q;
  logic [POS_W+1:0] ad_side;

  cts_div #(.NUM_W(Q_W), .DEN_W(TICK_W), .SIDE_W(1)) u_vdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m5_v_r),
    .in_num    (m5_vn_r),
    .in_den    (ticks_r),
    .in_side   (m5_vneg_r),
    .out_valid (vd_v),
    .out_quo   (vd_q),
    .out_side  (vd_neg)
  );

  cts_div #(.NUM_W(Q_W), .DEN_W(2*TICK_W), .SIDE_W(POS_W+2)) u_adiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m5_v_r),
    .in_num    (m5_an_r),
    .in_den    (tsq_r),
    .in_side   ({m5_pos_r, m5_aneg_r, m5_cl_r}),
    .out_valid (ad_v),
    .out_quo   (ad_q),
    .out_side  (ad_side)
  );

  // ---------------- saturate and sign ----------------
  logic [Q_W-1:0] vlim, alim, vsat, asat;
  logic           up_v;
  res_t           up_d;

  assign vlim = Q_W'(1) << (VEL_W-1);
  assign alim = Q_W'(1) << (ACC_W-1);

  always_comb begin
    // negative side reaches one step further than the positive side
    if (vd_neg) vsat = (vd_q > vlim) ? vlim : vd_q;
    else        vsat = (vd_q > (vlim - Q_W'(1))) ? (vlim - Q_W'(1)) : vd_q;
    if (ad_side[1]) asat = (ad_q > alim) ? alim : ad_q;
    else            asat = (ad_q > (alim - Q_W'(1))) ? (alim - Q_W'(1)) : ad_q;
  end

  assign up_v       = ad_v & vd_v;
  assign up_d.pos   = ad_side[POS_W+1:2];
  assign up_d.vel   = VEL_W'(vd_neg ? (~vsat + Q_W'(1)) : vsat);
  assign up_d.acc   = ACC_W'(ad_side[1] ? (~asat + Q_W'(1)) : asat);
  assign up_d.clamped = ad_side[0];

  // ---------------- output register and skid ----------------
  res_t out_d_r, sk_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (out_chan.ready || !out_v_r) begin
      // drain the skid first, otherwise take the pipe head
      out_v_r <= sk_v_r | up_v;
      sk_v_r  <= 1'b0;
    end else if (up_v && en) begin
      sk_v_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_chan.ready || !out_v_r) begin
      out_d_r <= sk_v_r ? sk_d_r : up_d;
    end else if (up_v && en) begin
      sk_d_r  <= up_d;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.position     = out_d_r.pos;
  assign out_chan.velocity     = out_d_r.vel;
  assign out_chan.acceleration = out_d_r.acc;
  assign out_chan.time_clamped = out_d_r.clamped;

endmodule

FILE: rtl/cts_div.sv
module cts_div #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [NUM_W:0]    v_r;
  logic [NUM_W-1:0]  num_r  [0:NUM_W];
  logic [NUM_W-1:0]  quo_r  [0:NUM_W];
  logic [DEN_W-1:0]  rem_r  [0:NUM_W];
  logic [DEN_W-1:0]  den_r  [0:NUM_W];
  logic [SIDE_W-1:0] side_r [0:NUM_W];

  logic [DEN_W:0] sh_w [0:NUM_W-1];
  logic [DEN_W:0] df_w [0:NUM_W-1];
  logic           ge_w [0:NUM_W-1];

  // one restoring step per stage: shift in the next numerator bit, try subtract
  always_comb begin
    for (int i = 0; i < NUM_W; i++) begin
      sh_w[i] = {rem_r[i], num_r[i][NUM_W-1]};
      df_w[i] = sh_w[i] - {1'b0, den_r[i]};
      ge_w[i] = ~df_w[i][DEN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NUM_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= in_num;
      quo_r[0]  <= '0;
      rem_r[0]  <= '0;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int i = 0; i < NUM_W; i++) begin
        num_r[i+1]  <= {num_r[i][NUM_W-2:0], 1'b0};
        quo_r[i+1]  <= {quo_r[i][NUM_W-2:0], ge_w[i]};
        rem_r[i+1]  <= ge_w[i] ? df_w[i][DEN_W-1:0] : sh_w[i][DEN_W-1:0];
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = v_r[NUM_W];
  assign out_quo   = quo_r[NUM_W];
  assign out_side  = side_r[NUM_W];

endmodule
